FILE: hw/rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the sparse matrix-vector accumulator.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int RowW       = 12;
  localparam int DataW      = 32;
  localparam int ProdW      = 48;
  localparam int QueueDepth = 8;

  // item opcodes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_NONZERO = 2'd1,
    OP_READ    = 2'd2,
    OP_EMPTY   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [RowW-1:0]           row_index;
    logic signed [DataW-1:0]   entry_value;
    logic signed [DataW-1:0]   column_operand;
    logic                      first_in_column;
    logic                      last_in_column;
  } request_t;

  typedef struct packed {
    logic signed [DataW-1:0]   result_value;
    logic                      is_read_data;
  } result_t;

  // store write seen by the forwarding network
  typedef struct packed {
    logic                      valid;
    logic [RowW-1:0]           row;
    logic signed [DataW-1:0]   data;
  } fwd_t;

  // item handed from front to back, store operand already resolved
  typedef struct packed {
    logic                      valid;
    request_t                  req;
    logic                      in_range;
    logic signed [DataW-1:0]   opnd;
  } stage_t;

endpackage

FILE: hw/rtl/csc_ram.sv
// ----------------------------------------------------------------------------
// csc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/csc_fifo.sv
// ----------------------------------------------------------------------------
// csc_fifo
// Small result queue in front of the output port.
// ----------------------------------------------------------------------------
module csc_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  csc_pkg::result_t       wr_item,
  input  logic                   rd,
  output csc_pkg::result_t       rd_item,
  output logic                   empty,
  output logic [$clog2(DEPTH):0] count
);
  import csc_pkg::*;

  localparam int PtrW = $clog2(DEPTH);

  result_t         mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            do_rd;

  assign empty   = (count == '0);
  assign do_rd   = rd && !empty;
  assign rd_item = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/csc_front.sv
// ----------------------------------------------------------------------------
// csc_front
// Accepts items, issues the store read and resolves the store operand
// against writes still in flight.
// ----------------------------------------------------------------------------
module csc_front #(
  parameter int VECTOR_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  csc_pkg::request_t               request,
  output logic [$clog2(VECTOR_DEPTH)-1:0] raddr,
  input  logic [csc_pkg::DataW-1:0]       rdata,
  input  csc_pkg::fwd_t                   fwd_s2,
  input  csc_pkg::fwd_t                   fwd_s3,
  input  csc_pkg::fwd_t                   fwd_last,
  output csc_pkg::stage_t                 s2
);
  import csc_pkg::*;

  localparam int AddrW = $clog2(VECTOR_DEPTH);

  logic                    s1_valid;
  request_t                s1_req;
  logic                    s1_in_range;
  logic                    in_range;
  logic signed [DataW-1:0] opnd;

  assign raddr    = AddrW'(request.row_index);
  assign in_range = 32'(request.row_index) < 32'(VECTOR_DEPTH);

  // newest pending write to the same row wins
  always_comb begin
    if (!s1_in_range) begin
      opnd = '0;
    end else if (fwd_s2.valid && fwd_s2.row == s1_req.row_index) begin
      opnd = fwd_s2.data;
    end else if (fwd_s3.valid && fwd_s3.row == s1_req.row_index) begin
      opnd = fwd_s3.data;
    end else if (fwd_last.valid && fwd_last.row == s1_req.row_index) begin
      opnd = fwd_last.data;
    end else begin
      opnd = $signed(rdata);
    end
  end

  // read stage and hand-off register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2.valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2.valid <= s1_valid;
    end
    s1_req      <= request;
    s1_in_range <= in_range;
    s2.req      <= s1_req;
    s2.in_range <= s1_in_range;
    s2.opnd     <= opnd;
  end

endmodule

FILE: hw/rtl/csc_back.sv
// ----------------------------------------------------------------------------
// csc_back
// Multiplies, accumulates with saturation, writes the store back and
// produces result items.
// ----------------------------------------------------------------------------
module csc_back #(
  parameter int VECTOR_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            transpose_mode,
  input  csc_pkg::stage_t                 s2,
  output csc_pkg::fwd_t                   fwd_s2,
  output csc_pkg::fwd_t                   fwd_s3,
  output csc_pkg::fwd_t                   fwd_last,
  output logic                            we,
  output logic [$clog2(VECTOR_DEPTH)-1:0] waddr,
  output logic [csc_pkg::DataW-1:0]       wdata,
  output logic                            retire,
  output logic                            res_push,
  output csc_pkg::result_t                res_item
);
  import csc_pkg::*;

  localparam int AddrW = $clog2(VECTOR_DEPTH);

  logic signed [2*DataW-1:0] prod_full;
  logic signed [DataW-1:0]   mul_b;
  logic                      s3_valid;
  request_t                  s3_req;
  logic                      s3_in_range;
  logic signed [DataW-1:0]   s3_y;
  logic signed [ProdW-1:0]   s3_prod;
  logic signed [DataW-1:0]   column_sum;
  logic signed [DataW-1:0]   column_sum_next;
  logic                      column_load;
  logic signed [DataW-1:0]   base;
  logic signed [ProdW:0]     sum_wide;
  logic signed [DataW-1:0]   sum_sat;

  // store writes from host items are known as early as the multiply stage
  assign fwd_s2.valid = s2.valid && s2.in_range && (s2.req.opcode == OP_WRITE);
  assign fwd_s2.row   = s2.req.row_index;
  assign fwd_s2.data  = s2.req.entry_value;

  // multiply stage
  assign mul_b     = transpose_mode ? s2.opnd : s2.req.column_operand;
  assign prod_full = s2.req.entry_value * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2.valid;
    end
    s3_req      <= s2.req;
    s3_in_range <= s2.in_range;
    s3_prod     <= prod_full[2*DataW-1:16];
    if (fwd_s3.valid && fwd_s3.row == s2.req.row_index) begin
      s3_y <= fwd_s3.data;
    end else begin
      s3_y <= s2.opnd;
    end
  end

  // accumulate and saturate
  always_comb begin
    if (transpose_mode) begin
      base = s3_req.first_in_column ? s3_req.column_operand : column_sum;
    end else begin
      base = s3_y;
    end
    sum_wide = (ProdW+1)'(base) + (ProdW+1)'(s3_prod);
    if (sum_wide > (ProdW+1)'(32'sh7fffffff)) begin
      sum_sat = 32'sh7fffffff;
    end else if (sum_wide < -(ProdW+1)'(33'sh080000000)) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum_wide[DataW-1:0];
    end
  end

  // writeback, column sum and results
  always_comb begin
    fwd_s3.valid    = 1'b0;
    fwd_s3.row      = s3_req.row_index;
    fwd_s3.data     = s3_req.entry_value;
    column_load     = 1'b0;
    column_sum_next = sum_sat;
    res_push        = 1'b0;
    res_item.result_value = sum_sat;
    res_item.is_read_data = 1'b0;
    if (s3_valid) begin
      unique case (s3_req.opcode)
        OP_WRITE: begin
          fwd_s3.valid = s3_in_range;
        end
        OP_READ: begin
          res_push = 1'b1;
          res_item.result_value = s3_y;
          res_item.is_read_data = 1'b1;
        end
        OP_EMPTY: begin
          if (transpose_mode) begin
            column_load     = 1'b1;
            column_sum_next = s3_req.column_operand;
            res_push        = 1'b1;
            res_item.result_value = s3_req.column_operand;
          end
        end
        OP_NONZERO: begin
          if (transpose_mode) begin
            column_load = 1'b1;
            res_push    = s3_req.last_in_column;
          end else begin
            fwd_s3.valid = s3_in_range;
            fwd_s3.data  = sum_sat;
          end
        end
        default: begin
          fwd_s3.valid = 1'b0;
        end
      endcase
    end
  end

  assign we     = fwd_s3.valid;
  assign waddr  = AddrW'(fwd_s3.row);
  assign wdata  = fwd_s3.data;
  assign retire = s3_valid;

  // running column sum and the write that just landed
  always_ff @(posedge clk) begin
    if (rst) begin
      column_sum     <= '0;
      fwd_last.valid <= 1'b0;
    end else begin
      if (column_load) begin
        column_sum <= column_sum_next;
      end
      fwd_last.valid <= fwd_s3.valid;
    end
    fwd_last.row  <= fwd_s3.row;
    fwd_last.data <= fwd_s3.data;
  end

endmodule

FILE: hw/rtl/csc_sparse_matvec_accumulate_top.sv
// ----------------------------------------------------------------------------
// csc_sparse_matvec_accumulate_top
// Streaming CSC sparse matrix-vector accumulator with a dense vector store.
// ----------------------------------------------------------------------------
// One item is accepted per clock while full is low. Each item passes a pipeline
// (store read and operand resolve, 32x32 multiply, saturating add and store
// write-back), with read-after-write forwarding so dependent nonzeros on
// the same row can follow back to back. Results go into an eight-entry
// queue; full rises when the queue plus items still in the pipeline could
// fill it. transpose_mode must only be written while the block is idle.
module csc_sparse_matvec_accumulate_top #(
  parameter int VECTOR_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  csc_pkg::request_t   request,
  output logic                empty,
  input  logic                pop,
  output csc_pkg::result_t    result,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import csc_pkg::*;

  localparam int AddrW = $clog2(VECTOR_DEPTH);
  localparam int CntW  = $clog2(QueueDepth) + 1;

  logic             transpose_mode;
  logic             accept;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  logic [DataW-1:0] rdata;
  logic [DataW-1:0] wdata;
  logic             we;
  stage_t           s2;
  fwd_t             fwd_s2;
  fwd_t             fwd_s3;
  fwd_t             fwd_last;
  logic             retire;
  logic             res_push;
  result_t          res_item;
  logic [CntW-1:0]  q_count;
  logic [1:0]       inflight;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_mode <= 1'b0;
    end else if (cfg_we) begin
      transpose_mode <= cfg_wdata;
    end
  end

  // credit check: every item in flight may still need a queue slot
  assign full   = (5'(q_count) + 5'(inflight)) >= 5'(QueueDepth);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (accept && !retire) begin
      inflight <= inflight + 1'b1;
    end else if (!accept && retire) begin
      inflight <= inflight - 1'b1;
    end
  end

  // vector store
  csc_ram #(
    .WIDTH (DataW),
    .DEPTH (VECTOR_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  csc_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .request  (request),
    .raddr    (raddr),
    .rdata    (rdata),
    .fwd_s2   (fwd_s2),
    .fwd_s3   (fwd_s3),
    .fwd_last (fwd_last),
    .s2       (s2)
  );

  csc_back #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .transpose_mode (transpose_mode),
    .s2             (s2),
    .fwd_s2         (fwd_s2),
    .fwd_s3         (fwd_s3),
    .fwd_last       (fwd_last),
    .we             (we),
    .waddr          (waddr),
    .wdata          (wdata),
    .retire         (retire),
    .res_push       (res_push),
    .res_item       (res_item)
  );

  // result queue
  csc_fifo #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_item (res_item),
    .rd      (pop),
    .rd_item (result),
    .empty   (empty),
    .count   (q_count)
  );

endmodule

FILE: bench/csc_sparse_matvec_accumulate_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csc_sparse_matvec_accumulate_top_tb
// Self-checking bench for the CSC sparse matrix-vector accumulator. A short
// directed table covers the extremes and the column and mode corner cases,
// then random phases mix scatter and gather modes. Every accepted item
// is run through an in-bench predictor, and results are compared in order.
// ----------------------------------------------------------------------------
module csc_sparse_matvec_accumulate_top_tb;
  import csc_pkg::*;

  localparam int DEPTH      = 4096;
  localparam int DRAIN      = 12;
  localparam int IDLE_LIMIT = 5000;
  localparam int SQUEEZE    = 400;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  request_t request = '0;
  logic     empty;
  logic     pop = 1'b0;
  result_t  result;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;

  csc_sparse_matvec_accumulate_top #(.VECTOR_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] y_store [DEPTH];
  bit                 written [DEPTH];
  int                 written_rows[$];
  logic signed [31:0] col_sum;
  bit                 gather_mode;
  result_t            pending[$];
  int                 errors;
  bit                 squeeze;
  bit                 squeezed;
  bit                 calm;
  int                 stall_cnt;
  int                 idle_cnt;

  // full-width product, low 16 bits dropped
  function automatic longint q_mul(logic signed [31:0] a,
                                   logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 longint b);
    longint s;
    s = longint'(a) + b;
    if (s > longint'(Q_MAX)) return Q_MAX;
    if (s < longint'(Q_MIN)) return Q_MIN;
    return 32'(s);
  endfunction

  // apply one accepted item to the predicted state, return its result if any
  function automatic bit predict_item(request_t r, output result_t res);
    logic signed [31:0] base;
    res = '0;
    case (r.opcode)
      OP_WRITE: begin
        y_store[r.row_index] = r.entry_value;
        if (!written[r.row_index]) begin
          written[r.row_index] = 1'b1;
          written_rows.push_back(r.row_index);
        end
        return 1'b0;
      end
      OP_READ: begin
        res.result_value = y_store[r.row_index];
        res.is_read_data = 1'b1;
        return 1'b1;
      end
      OP_EMPTY: begin
        if (!gather_mode) return 1'b0;
        col_sum = r.column_operand;
        res.result_value = r.column_operand;
        return 1'b1;
      end
      default: begin
        if (!gather_mode) begin
          y_store[r.row_index] = sat_add(y_store[r.row_index],
                                         q_mul(r.entry_value, r.column_operand));
          return 1'b0;
        end
        base = r.first_in_column ? r.column_operand : col_sum;
        col_sum = sat_add(base, q_mul(r.entry_value, y_store[r.row_index]));
        res.result_value = col_sum;
        return r.last_in_column;
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [31:0] pick_q();
    case ($urandom_range(7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'($urandom);
      3: return 0;
      4: return $urandom_range(1) ? Q_ONE : -Q_ONE;
      default: return 32'($signed($urandom_range(6 << 16)) - (3 << 16));
    endcase
  endfunction

  function automatic logic [11:0] pick_row();
    return 12'(written_rows[$urandom_range(written_rows.size() - 1)]);
  endfunction

  // offer one item until accepted, then idle for a random gap
  task automatic send(request_t r, bit typed = 1'b0, result_t typed_res = '0);
    result_t res;
    int gap;
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
    if (predict_item(r, res)) pending.push_back(typed ? typed_res : res);
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mode change only once the block has gone quiet
  task automatic set_mode(bit m);
    push <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we      <= 1'b0;
    gather_mode = m;
  endtask

  function automatic request_t mk(opcode_t op, logic [11:0] row,
                                  logic signed [31:0] v, logic signed [31:0] x,
                                  bit f, bit l);
    request_t r;
    r.opcode = op;
    r.row_index = row;
    r.entry_value = v;
    r.column_operand = x;
    r.first_in_column = f;
    r.last_in_column = l;
    return r;
  endfunction

  function automatic request_t rand_noise();
    request_t r;
    r = mk(opcode_t'($urandom_range(3)), pick_row(), pick_q(), pick_q(),
           1'($urandom_range(1)), 1'($urandom_range(1)));
    if (r.opcode == OP_WRITE && $urandom_range(1)) r.row_index = 12'($urandom);
    return r;
  endfunction

  // directed table
  typedef struct {
    bit       mode;
    request_t req;
    bit       typed;
    result_t  res;
  } vec_t;

  vec_t vecs[$];

  task automatic add_vec(bit m, request_t r, bit t = 1'b0,
                         logic signed [31:0] v = 0, bit rd = 1'b0);
    vec_t e;
    e.mode = m;
    e.req = r;
    e.typed = t;
    e.res.result_value = v;
    e.res.is_read_data = rd;
    vecs.push_back(e);
  endtask

  // stimulus
  initial begin
    int len;
    bit m;
    bit modes[7] = '{0, 1, 0, 1, 1, 0, 1};
    errors = 0;
    gather_mode = 1'b0;
    col_sum = 0;
    squeeze = 1'b0;
    calm = 1'b0;
    foreach (y_store[i]) y_store[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // scatter mode: extremes, saturation, ignored marks
    add_vec(0, mk(OP_WRITE, 12'd0, Q_MAX, 0, 0, 0));
    add_vec(0, mk(OP_WRITE, 12'd4095, Q_MIN, 0, 0, 0));
    add_vec(0, mk(OP_WRITE, 12'd1, Q_ONE, 0, 0, 0));
    add_vec(0, mk(OP_WRITE, 12'd2, 0, 0, 0, 0));
    add_vec(0, mk(OP_READ, 12'd0, 0, 0, 0, 0), 1, Q_MAX, 1);
    add_vec(0, mk(OP_READ, 12'd4095, 0, 0, 0, 0), 1, Q_MIN, 1);
    add_vec(0, mk(OP_NONZERO, 12'd1, Q_ONE, 32'sh00020000, 1, 1));
    add_vec(0, mk(OP_NONZERO, 12'd1, Q_ONE, Q_ONE, 0, 0));
    add_vec(0, mk(OP_READ, 12'd1, 0, 0, 0, 0), 1, 32'sh00040000, 1);
    add_vec(0, mk(OP_NONZERO, 12'd0, Q_MAX, Q_MAX, 0, 0));
    add_vec(0, mk(OP_NONZERO, 12'd4095, Q_MAX, -Q_ONE, 0, 1));
    add_vec(0, mk(OP_EMPTY, 12'd2, Q_MAX, Q_MAX, 1, 1));
    add_vec(0, mk(OP_READ, 12'd0, 0, 0, 0, 0), 1, Q_MAX, 1);
    add_vec(0, mk(OP_READ, 12'd4095, 0, 0, 0, 0), 1, Q_MIN, 1);
    // gather mode: empty column, floor on negatives, continuation, clamps
    add_vec(1, mk(OP_EMPTY, 12'd0, 0, 32'sh12345678, 0, 0), 1, 32'sh12345678, 0);
    add_vec(1, mk(OP_NONZERO, 12'd1, -32'sd1, 0, 1, 1));
    add_vec(1, mk(OP_NONZERO, 12'd1, Q_ONE, 32'sh00050000, 1, 0));
    add_vec(1, mk(OP_NONZERO, 12'd2, Q_MAX, Q_MIN, 1, 0));
    add_vec(1, mk(OP_NONZERO, 12'd0, Q_MAX, 0, 0, 1), 1, Q_MAX, 0);
    add_vec(1, mk(OP_NONZERO, 12'd4095, Q_MAX, Q_MIN, 1, 1), 1, Q_MIN, 0);
    add_vec(1, mk(OP_NONZERO, 12'd0, -Q_ONE, -Q_ONE, 0, 1));
    add_vec(1, mk(OP_READ, 12'd1, 0, 0, 1, 1));

    set_mode(1'b0);
    foreach (vecs[i]) begin
      if (vecs[i].mode != gather_mode) set_mode(vecs[i].mode);
      send(vecs[i].req, vecs[i].typed, vecs[i].res);
    end

    // random phases
    for (int ph = 0; ph < 7; ph++) begin
      m = modes[ph];
      set_mode(m);
      calm = (ph == 4);
      squeeze = (ph == 2);
      for (int n = 0; n < 120; ) begin
        if (!m || $urandom_range(99) < 15) begin
          send(rand_noise());
          n++;
        end else begin
          // well-formed column with random content
          len = $urandom_range(5);
          if (len == 0) begin
            send(mk(OP_EMPTY, pick_row(), pick_q(), pick_q(),
                    1'($urandom_range(1)), 1'($urandom_range(1))));
            n++;
          end
          for (int k = 0; k < len; k++) begin
            send(mk(OP_NONZERO, pick_row(), pick_q(), pick_q(), k == 0,
                    k == len - 1));
            n++;
          end
        end
      end
    end
    push <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: check and random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      stall_cnt <= 0;
      squeezed  <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending.size() == 0) begin
          $error("result with nothing expected: value %h", result.result_value);
          errors++;
        end else begin
          if (result.result_value !== pending[0].result_value) begin
            $error("result_value: expected %h, actual %h",
                   pending[0].result_value, result.result_value);
            errors++;
          end
          if (result.is_read_data !== pending[0].is_read_data) begin
            $error("is_read_data: expected %b, actual %b",
                   pending[0].is_read_data, result.is_read_data);
            errors++;
          end
          void'(pending.pop_front());
        end
      end
      if (squeeze && !squeezed) begin
        pop       <= 1'b0;
        stall_cnt <= SQUEEZE;
        squeezed  <= 1'b1;
      end else if (stall_cnt > 0) begin
        pop       <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else if (!calm && $urandom_range(99) < 25) begin
        pop       <= 1'b0;
        stall_cnt <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                              : $urandom_range(3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial idle_cnt = 0;

endmodule

FILE: filelist.f
hw/rtl/csc_pkg.sv
hw/rtl/csc_ram.sv
hw/rtl/csc_fifo.sv
hw/rtl/csc_front.sv
hw/rtl/csc_back.sv
hw/rtl/csc_sparse_matvec_accumulate_top.sv
bench/csc_sparse_matvec_accumulate_top_tb.sv
